[hdl/tmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types and constants of the TCP SYN MSS clamp.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [6:0]  IP_HLEN     = 7'd20;
  localparam logic [6:0]  OPT_START   = 7'd40;
  localparam logic [6:0]  MAX_PKT     = 7'd80;
  localparam logic [6:0]  POS_PROTO   = 7'd9;
  localparam logic [6:0]  POS_DOFF    = 7'd32;
  localparam logic [6:0]  POS_FLAGS   = 7'd33;
  localparam logic [6:0]  POS_CKS_HI  = 7'd36;
  localparam logic [6:0]  POS_CKS_LO  = 7'd37;
  localparam logic [6:0]  POS_MAX     = 7'd127;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  OPT_EOL     = 8'd0;
  localparam logic [7:0]  OPT_NOP     = 8'd1;
  localparam logic [7:0]  OPT_MSS     = 8'd2;
  localparam logic [7:0]  OPT_MD5     = 8'd19;
  localparam logic [7:0]  MSS_OPT_LEN = 8'd4;
  localparam logic [15:0] MAX_MSS_RST = 16'd1200;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_SKIP = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_PATCHED   = 4'd0,
    ST_NOT_TCP   = 4'd1,
    ST_NO_SYN    = 4'd2,
    ST_LEN_MIS   = 4'd3,
    ST_NO_OPTS   = 4'd4,
    ST_MALFORMED = 4'd5,
    ST_MD5       = 4'd6,
    ST_NO_MSS    = 4'd7,
    ST_BAD_LEN   = 4'd8,
    ST_NO_PATCH  = 4'd9
  } status_t;

  typedef struct packed {
    logic        tcp;
    logic        syn;
    logic        len4;
    logic        len_bad;
    logic        no_opts;
    logic        err_malformed;
    logic        err_md5;
    logic [6:0]  found_offset;
    logic [15:0] mss;
    logic [15:0] cks;
  } summary_t;

endpackage
`default_nettype wire

[hdl/tmc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmc_front
// Byte parser: tracks header fields and scans TCP options, one byte per cycle
// while accept is high, and hands a per-packet summary to the queue on the last byte.
// ----------------------------------------------------------------------------
module tmc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   sum_valid,
  output tmc_pkg::summary_t      sum_data
);
  import tmc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  byte_index_r, byte_index_nxt;
  logic [6:0]  thl_r, thl_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [6:0]  found_r, found_nxt;
  logic [15:0] mss_r, mss_nxt;
  logic [15:0] cks_r, cks_nxt;
  logic        tcp_r, tcp_nxt;
  logic        syn_r, syn_nxt;
  logic        len4_r, len4_nxt;
  logic        mal_r, mal_nxt;
  logic        md5_r, md5_nxt;

  logic [6:0]  pos;
  logic [6:0]  thl_cur;
  logic [6:0]  end_w;
  logic [7:0]  pos_p1;
  logic [8:0]  opt_end;
  logic        scan_act;
  logic        kind_short;
  logic        len_bad_opt;
  logic        is_md5;
  logic [7:0]  skip_len;
  logic [7:0]  skip_dec;
  logic        take_mss;

  assign pos         = byte_index_r;
  assign thl_cur     = (pos == POS_DOFF) ? {1'b0, data_byte[7:4], 2'b00} : thl_r;
  assign end_w       = thl_cur + IP_HLEN;
  assign pos_p1      = {1'b0, pos} + 8'd1;
  assign opt_end     = {2'b00, pos} - 9'd1 + {1'b0, data_byte};
  assign scan_act    = (pos >= OPT_START) && (pos < end_w) && (phase_r != PH_DONE);
  assign kind_short  = pos_p1 >= {1'b0, end_w};
  assign len_bad_opt = (data_byte < 8'd2) || (opt_end > {2'b00, end_w});
  assign is_md5      = kind_r == OPT_MD5;
  assign skip_len    = data_byte - 8'd2;
  assign skip_dec    = skip_r - 8'd1;
  assign take_mss    = (kind_r == OPT_MSS) && (found_r == 7'd0);

  // Option scan phase.
  always_comb begin
    phase_nxt = phase_r;
    if (scan_act) begin
      unique case (phase_r)
        PH_KIND: begin
          if (data_byte == OPT_EOL) begin
            phase_nxt = PH_DONE;
          end else if (data_byte != OPT_NOP) begin
            phase_nxt = kind_short ? PH_DONE : PH_LEN;
          end
        end
        PH_LEN: begin
          if (len_bad_opt || is_md5) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = (skip_len != 8'd0) ? PH_SKIP : PH_KIND;
          end
        end
        PH_SKIP: begin
          if (skip_dec == 8'd0) begin
            phase_nxt = PH_KIND;
          end
        end
        default: phase_nxt = PH_DONE;
      endcase
    end
  end

  // Header capture and scan data updates.
  always_comb begin
    byte_index_nxt = (byte_index_r < POS_MAX) ? byte_index_r + 7'd1 : byte_index_r;
    thl_nxt  = thl_cur;
    skip_nxt = skip_r;
    kind_nxt = kind_r;
    found_nxt = found_r;
    mss_nxt  = mss_r;
    cks_nxt  = cks_r;
    tcp_nxt  = tcp_r || ((pos == POS_PROTO) && (data_byte == PROTO_TCP));
    syn_nxt  = syn_r || ((pos == POS_FLAGS) && data_byte[1]);
    len4_nxt = len4_r;
    mal_nxt  = mal_r;
    md5_nxt  = md5_r;
    if (pos == POS_CKS_HI) begin
      cks_nxt = {data_byte, cks_r[7:0]};
    end
    if (pos == POS_CKS_LO) begin
      cks_nxt = {cks_r[15:8], data_byte};
    end
    if (scan_act) begin
      unique case (phase_r)
        PH_KIND: begin
          if ((data_byte != OPT_EOL) && (data_byte != OPT_NOP)) begin
            if (kind_short) begin
              mal_nxt = 1'b1;
            end else begin
              kind_nxt = data_byte;
            end
          end
        end
        PH_LEN: begin
          if (len_bad_opt) begin
            mal_nxt = 1'b1;
          end else if (is_md5) begin
            md5_nxt = 1'b1;
          end else begin
            if (take_mss) begin
              found_nxt = pos - 7'd1;
              len4_nxt  = data_byte == MSS_OPT_LEN;
            end
            skip_nxt = skip_len;
          end
        end
        PH_SKIP: begin
          if ((found_r != 7'd0) && len4_r) begin
            if ({1'b0, pos} == {1'b0, found_r} + 8'd2) begin
              mss_nxt = {data_byte, mss_r[7:0]};
            end else if ({1'b0, pos} == {1'b0, found_r} + 8'd3) begin
              mss_nxt = {mss_r[15:8], data_byte};
            end
          end
          skip_nxt = skip_dec;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sum_valid              = accept && last_byte;
    sum_data.tcp           = tcp_nxt;
    sum_data.syn           = syn_nxt;
    sum_data.len4          = len4_nxt;
    sum_data.len_bad       = (pos >= MAX_PKT) || (pos_p1 != {1'b0, end_w});
    sum_data.no_opts       = thl_cur <= IP_HLEN;
    sum_data.err_malformed = mal_nxt;
    sum_data.err_md5       = md5_nxt;
    sum_data.found_offset  = found_nxt;
    sum_data.mss           = mss_nxt;
    sum_data.cks           = cks_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      phase_r      <= PH_KIND;
      byte_index_r <= 7'd0;
      thl_r        <= 7'd0;
      skip_r       <= 8'd0;
      kind_r       <= 8'd0;
      found_r      <= 7'd0;
      mss_r        <= 16'd0;
      cks_r        <= 16'd0;
      tcp_r        <= 1'b0;
      syn_r        <= 1'b0;
      len4_r       <= 1'b0;
      mal_r        <= 1'b0;
      md5_r        <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      thl_r        <= thl_nxt;
      skip_r       <= skip_nxt;
      kind_r       <= kind_nxt;
      found_r      <= found_nxt;
      mss_r        <= mss_nxt;
      cks_r        <= cks_nxt;
      tcp_r        <= tcp_nxt;
      syn_r        <= syn_nxt;
      len4_r       <= len4_nxt;
      mal_r        <= mal_nxt;
      md5_r        <= md5_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/tmc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmc_queue
// Short queue of packet summaries between the parser and the result stage.
// ----------------------------------------------------------------------------
module tmc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire tmc_pkg::summary_t wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output tmc_pkg::summary_t      rd_data,
  output logic                   empty
);
  import tmc_pkg::*;

  summary_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = count_r == (QAW+1)'(QDEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_rd ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[hdl/tmc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmc_back
// Result stage: ranks the status, applies the clamp, updates the checksum
// and holds the result word until it is popped. Owns the max_mss register.
// ----------------------------------------------------------------------------
module tmc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic [15:0]       cfg_max_mss,
  input  wire tmc_pkg::summary_t q_data,
  input  wire logic              q_empty,
  output logic                   q_rd,
  input  wire logic              pop,
  output logic                   empty,
  output logic [3:0]             status,
  output logic                   patched,
  output logic [6:0]             mss_offset,
  output logic [15:0]            old_mss,
  output logic [15:0]            new_mss,
  output logic [15:0]            new_checksum
);
  import tmc_pkg::*;

  logic [15:0] max_mss_r;
  logic        valid_r;
  status_t     status_r, status_nxt;
  logic        patched_r, patched_nxt;
  logic [6:0]  offset_r, offset_nxt;
  logic [15:0] old_r, old_nxt;
  logic [15:0] new_r, new_nxt;
  logic [15:0] cks_r, cks_nxt;

  logic [17:0] sum1;
  logic [16:0] sum2;
  logic [15:0] sum3;

  assign q_rd = !q_empty && (!valid_r || pop);

  always_comb begin
    sum1 = {2'b00, ~q_data.cks} + {2'b00, ~q_data.mss} + {2'b00, max_mss_r};
    sum2 = {1'b0, sum1[15:0]} + {15'd0, sum1[17:16]};
    sum3 = sum2[15:0] + {15'd0, sum2[16]};
  end

  always_comb begin
    if (!q_data.tcp) begin
      status_nxt = ST_NOT_TCP;
    end else if (!q_data.syn) begin
      status_nxt = ST_NO_SYN;
    end else if (q_data.len_bad) begin
      status_nxt = ST_LEN_MIS;
    end else if (q_data.no_opts) begin
      status_nxt = ST_NO_OPTS;
    end else if (q_data.err_malformed) begin
      status_nxt = ST_MALFORMED;
    end else if (q_data.err_md5) begin
      status_nxt = ST_MD5;
    end else if (q_data.found_offset == 7'd0) begin
      status_nxt = ST_NO_MSS;
    end else if (!q_data.len4) begin
      status_nxt = ST_BAD_LEN;
    end else if (q_data.mss <= max_mss_r) begin
      status_nxt = ST_NO_PATCH;
    end else begin
      status_nxt = ST_PATCHED;
    end
  end

  always_comb begin
    patched_nxt = 1'b0;
    offset_nxt  = 7'd0;
    old_nxt     = 16'd0;
    new_nxt     = 16'd0;
    cks_nxt     = 16'd0;
    case (status_nxt)
      ST_PATCHED: begin
        patched_nxt = 1'b1;
        offset_nxt  = q_data.found_offset + 7'd2;
        old_nxt     = q_data.mss;
        new_nxt     = max_mss_r;
        cks_nxt     = ~sum3;
      end
      ST_NO_PATCH: begin
        offset_nxt = q_data.found_offset + 7'd2;
        old_nxt    = q_data.mss;
        new_nxt    = q_data.mss;
        cks_nxt    = q_data.cks;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mss_r <= MAX_MSS_RST;
    end else if (cfg_valid) begin
      max_mss_r <= cfg_max_mss;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_rd) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      status_r  <= status_nxt;
      patched_r <= patched_nxt;
      offset_r  <= offset_nxt;
      old_r     <= old_nxt;
      new_r     <= new_nxt;
      cks_r     <= cks_nxt;
    end
  end

  assign empty        = !valid_r;
  assign status       = status_r;
  assign patched      = patched_r;
  assign mss_offset   = offset_r;
  assign old_mss      = old_r;
  assign new_mss      = new_r;
  assign new_checksum = cks_r;

endmodule
`default_nettype wire

[hdl/tcp_syn_mss_clamp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_syn_mss_clamp
// Checks IPv4 TCP SYN packets, one byte per word, and reports the MSS clamp
// and checksum rewrite for each packet on its last byte.
//
//   channel  direction  handshake          word
//   in_      input      in_push / in_full    data_byte, last_byte
//   out_     output     out_empty / out_pop  status, patched, offset, MSS, csum
//   cfg_     input      cfg_valid / cfg_ready  max_mss
//
// One byte is taken every cycle while in_full is low; the parser state is registered.
// A last byte queues the packet's summary; the result stage then registers it.
// Reset is synchronous; max_mss returns to 1200.
// in_full rises only when the four-entry summary queue is full, which
// happens when results are not popped; cfg_ready is always high.
// ----------------------------------------------------------------------------
module tcp_syn_mss_clamp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [3:0]       out_status,
  output logic             out_patched,
  output logic [6:0]       out_mss_offset,
  output logic [15:0]      out_old_mss,
  output logic [15:0]      out_new_mss,
  output logic [15:0]      out_new_checksum,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_max_mss
);
  import tmc_pkg::*;

  logic     accept;
  logic     sum_valid;
  summary_t sum_data;
  summary_t q_data;
  logic     q_full;
  logic     q_empty;
  logic     q_rd;

  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign cfg_ready = 1'b1;

  tmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .sum_valid (sum_valid),
    .sum_data  (sum_data)
  );

  tmc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (sum_valid),
    .wr_data (sum_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  tmc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_max_mss  (cfg_max_mss),
    .q_data       (q_data),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .pop          (out_pop),
    .empty        (out_empty),
    .status       (out_status),
    .patched      (out_patched),
    .mss_offset   (out_mss_offset),
    .old_mss      (out_old_mss),
    .new_mss      (out_new_mss),
    .new_checksum (out_new_checksum)
  );

endmodule
`default_nettype wire

[hdl/tmc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmc_checker
// Port-level checks of the MSS clamp, bound to the top level.
// ----------------------------------------------------------------------------
module tmc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [3:0]  out_status,
  input wire logic        out_patched,
  input wire logic [6:0]  out_mss_offset,
  input wire logic [15:0] out_old_mss,
  input wire logic [15:0] out_new_mss,
  input wire logic [15:0] out_new_checksum
);
  import tmc_pkg::*;

  // Reset leaves no result shown.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_status)
      && $stable(out_new_checksum))
    else $error("waiting result word changed");

  a_patch_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_patched == (out_status == ST_PATCHED)) && (out_status <= ST_NO_PATCH))
    else $error("patched flag disagrees with status");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_patched |-> out_new_mss < out_old_mss)
    else $error("patched MSS is not smaller than the received one");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_status != ST_PATCHED) && (out_status != ST_NO_PATCH)
      |-> (out_mss_offset == 7'd0) && (out_old_mss == 16'd0) && (out_new_mss == 16'd0)
      && (out_new_checksum == 16'd0))
    else $error("rejected packet carries nonzero fields");

endmodule

bind tcp_syn_mss_clamp tmc_checker u_tmc_checker (.*);
`default_nettype wire

[tb/sv/mss_clamp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_clamp_checker
// Watches the byte, result and limit channels of the MSS clamp, runs its own
// packet parser on every accepted byte and compares each popped result word
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module mss_clamp_checker
  import tmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic        in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        out_empty,
  input  wire logic        out_pop,
  input  wire logic [3:0]  out_status,
  input  wire logic        out_patched,
  input  wire logic [6:0]  out_mss_offset,
  input  wire logic [15:0] out_old_mss,
  input  wire logic [15:0] out_new_mss,
  input  wire logic [15:0] out_new_checksum,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_max_mss,
  output int               errors,
  output int               waiting
);

  localparam logic [15:0] RESET_LIMIT  = 16'd1200;
  localparam int          TCP_MIN_HLEN = 20;

  typedef struct packed {
    status_t     st;
    logic        patched;
    logic [6:0]  off;
    logic [15:0] old_mss;
    logic [15:0] new_mss;
    logic [15:0] cks;
  } clamp_result_t;

  clamp_result_t clamp_due[$];

  logic [15:0] mss_limit;
  logic [6:0]  pkt_pos;
  logic [6:0]  hdr_len;
  phase_t      opt_phase;
  logic [7:0]  opt_left;
  logic [7:0]  opt_kind;
  logic [6:0]  mss_at;
  logic [15:0] mss_seen;
  logic [15:0] cks_seen;
  logic        scan_bad;
  status_t     scan_code;
  logic        is_tcp;
  logic        is_syn;
  logic        mss_len4;

  function automatic logic [15:0] cks_rewrite(logic [15:0] cks, logic [15:0] old_v,
                                              logic [15:0] new_v);
    logic [31:0] acc;
    acc = {16'h0, ~cks} + {16'h0, ~old_v} + {16'h0, new_v};
    acc = {16'h0, acc[31:16]} + {16'h0, acc[15:0]};
    acc = acc + {16'h0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  task automatic clear_pkt();
    pkt_pos   = '0;
    hdr_len   = '0;
    opt_phase = PH_KIND;
    opt_left  = '0;
    opt_kind  = '0;
    mss_at    = '0;
    mss_seen  = '0;
    cks_seen  = '0;
    scan_bad  = 1'b0;
    scan_code = ST_MALFORMED;
    is_tcp    = 1'b0;
    is_syn    = 1'b0;
    mss_len4  = 1'b0;
  endtask

  task automatic scan_fail(input status_t code);
    scan_bad  = 1'b1;
    scan_code = code;
    opt_phase = PH_DONE;
  endtask

  task automatic clamp_byte(input logic [7:0] b, input logic last);
    int pos;
    int stop;
    int len;
    clamp_result_t r;
    pos = pkt_pos;
    if (pos == POS_PROTO && b == PROTO_TCP) is_tcp = 1'b1;
    if (pos == POS_DOFF) hdr_len = {1'b0, b[7:4], 2'b00};
    if (pos == POS_FLAGS && b[1]) is_syn = 1'b1;
    if (pos == POS_CKS_HI) cks_seen[15:8] = b;
    if (pos == POS_CKS_LO) cks_seen[7:0] = b;
    stop = int'(hdr_len) + int'(IP_HLEN);

    if (pos >= OPT_START && pos < stop && opt_phase != PH_DONE) begin
      case (opt_phase)
        PH_KIND: begin
          if (b == OPT_EOL) begin
            opt_phase = PH_DONE;
          end else if (b != OPT_NOP) begin
            if (pos + 1 >= stop) begin
              scan_fail(ST_MALFORMED);
            end else begin
              opt_kind  = b;
              opt_phase = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          len = b;
          if (len < 2 || pos - 1 + len > stop) begin
            scan_fail(ST_MALFORMED);
          end else if (opt_kind == OPT_MD5) begin
            scan_fail(ST_MD5);
          end else begin
            if (opt_kind == OPT_MSS && mss_at == 0) begin
              mss_at = 7'(pos - 1);
              if (b == MSS_OPT_LEN) mss_len4 = 1'b1;
            end
            opt_left  = 8'(len - 2);
            opt_phase = (opt_left != 0) ? PH_SKIP : PH_KIND;
          end
        end
        default: begin
          if (mss_at != 0 && mss_len4) begin
            if (pos == int'(mss_at) + 2) mss_seen[15:8] = b;
            else if (pos == int'(mss_at) + 3) mss_seen[7:0] = b;
          end
          opt_left = opt_left - 8'd1;
          if (opt_left == 0) opt_phase = PH_KIND;
        end
      endcase
    end

    if (pkt_pos < POS_MAX) pkt_pos = pkt_pos + 7'd1;

    if (last) begin
      r = '0;
      if (!is_tcp) r.st = ST_NOT_TCP;
      else if (!is_syn) r.st = ST_NO_SYN;
      else if (pos >= MAX_PKT || pos + 1 != stop) r.st = ST_LEN_MIS;
      else if (hdr_len <= TCP_MIN_HLEN) r.st = ST_NO_OPTS;
      else if (scan_bad) r.st = scan_code;
      else if (mss_at == 0) r.st = ST_NO_MSS;
      else if (!mss_len4) r.st = ST_BAD_LEN;
      else if (mss_seen <= mss_limit) r.st = ST_NO_PATCH;
      else r.st = ST_PATCHED;
      if (r.st == ST_PATCHED || r.st == ST_NO_PATCH) begin
        r.off     = mss_at + 7'd2;
        r.old_mss = mss_seen;
        if (r.st == ST_PATCHED) begin
          r.patched = 1'b1;
          r.new_mss = mss_limit;
          r.cks     = cks_rewrite(cks_seen, mss_seen, mss_limit);
        end else begin
          r.new_mss = mss_seen;
          r.cks     = cks_seen;
        end
      end
      clamp_due.push_back(r);
      clear_pkt();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    clamp_result_t want;
    if (!rst_n) begin
      mss_limit = RESET_LIMIT;
      clear_pkt();
      clamp_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) mss_limit = cfg_max_mss;
      if (out_pop && !out_empty) begin
        if (clamp_due.size() == 0) begin
          errors++;
          $display("%0t ns: result word expected none, got status %0d", $time, out_status);
        end else begin
          want = clamp_due.pop_front();
          check_field("status", 16'(want.st), 16'(out_status));
          check_field("patched", 16'(want.patched), 16'(out_patched));
          check_field("mss_offset", 16'(want.off), 16'(out_mss_offset));
          check_field("old_mss", want.old_mss, out_old_mss);
          check_field("new_mss", want.new_mss, out_new_mss);
          check_field("new_checksum", want.cks, out_new_checksum);
        end
      end
      if (in_push && !in_full) clamp_byte(in_data_byte, in_last_byte);
    end
    waiting = clamp_due.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the MSS clamp with hand-built and random IPv4 packets one byte word
// at a time, changes the MSS limit between phases, varies the idle pattern
// on both channels and stalls the result side long enough to back up the
// input, then reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import tmc_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         SYN_BIT     = 1;
  localparam logic [7:0] OPT_TSTAMP  = 8'd8;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_push      = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_pop      = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [15:0] cfg_max_mss  = 16'd0;
  logic        in_full;
  logic        out_empty;
  logic [3:0]  out_status;
  logic        out_patched;
  logic [6:0]  out_mss_offset;
  logic [15:0] out_old_mss;
  logic [15:0] out_new_mss;
  logic [15:0] out_new_checksum;
  logic        cfg_ready;

  int          errors;
  int          waiting;
  int          cycles     = 0;
  int          send_idle  = 25;
  int          recv_idle  = 83;
  int          hold_left  = 0;
  int          bytes_sent = 0;
  logic [15:0] limit_now  = 16'd1200;
  logic [7:0]  pkt[$];

  tcp_syn_mss_clamp uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_patched      (out_patched),
    .out_mss_offset   (out_mss_offset),
    .out_old_mss      (out_old_mss),
    .out_new_mss      (out_new_mss),
    .out_new_checksum (out_new_checksum),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_mss      (cfg_max_mss)
  );

  mss_clamp_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_patched      (out_patched),
    .out_mss_offset   (out_mss_offset),
    .out_old_mss      (out_old_mss),
    .out_new_mss      (out_new_mss),
    .out_new_checksum (out_new_checksum),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_mss      (cfg_max_mss),
    .errors           (errors),
    .waiting          (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[tcp_syn_mss_clamp] ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    bytes_sent += pkt.size();
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    cfg_valid   <= 1'b1;
    cfg_max_mss <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  task automatic set_doff(input logic [3:0] d);
    pkt[POS_DOFF] = {d, pkt[POS_DOFF][3:0]};
  endtask

  task automatic begin_syn(input logic tcp, input logic syn);
    logic [7:0] v;
    logic [7:0] f;
    pkt.delete();
    repeat (40) pkt.push_back(8'($urandom_range(255)));
    v = 8'($urandom_range(1, 255));
    pkt[POS_PROTO] = tcp ? PROTO_TCP : PROTO_TCP + v;
    f = pkt[POS_FLAGS];
    f[SYN_BIT] = syn;
    pkt[POS_FLAGS] = f;
  endtask

  task automatic add_mss(input logic [15:0] v);
    pkt.push_back(OPT_MSS);
    pkt.push_back(MSS_OPT_LEN);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  task automatic add_opt(input logic [7:0] kind, input int len);
    pkt.push_back(kind);
    pkt.push_back(8'(len));
    for (int i = 2; i < len; i++) pkt.push_back(8'($urandom_range(255)));
  endtask

  task automatic close_options();
    while ((pkt.size() % 4) != 0) pkt.push_back(OPT_EOL);
    if (pkt.size() > int'(MAX_PKT)) pkt = pkt[0:int'(MAX_PKT) - 1];
    set_doff(4'((pkt.size() - int'(IP_HLEN)) / 4));
  endtask

  function automatic logic [15:0] mss_pick();
    case ($urandom_range(5))
      0: return limit_now - 16'd1;
      1: return limit_now;
      2: return limit_now + 16'd1;
      3: return 16'd0;
      4: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] other_kind();
    logic [7:0] k;
    do begin
      k = 8'($urandom_range(255));
    end while (k == OPT_EOL || k == OPT_NOP || k == OPT_MSS || k == OPT_MD5);
    return k;
  endfunction

  task automatic random_packet();
    int n;
    int roll;
    if ($urandom_range(99) < 10) begin
      pkt.delete();
      n = $urandom_range(1, 90);
      repeat (n) pkt.push_back(8'($urandom_range(255)));
      if (n > 9 && $urandom_range(1)) pkt[POS_PROTO] = PROTO_TCP;
    end else begin
      begin_syn($urandom_range(99) >= 5, $urandom_range(99) >= 5);
      if ($urandom_range(99) < 60) begin
        repeat ($urandom_range(2)) pkt.push_back(OPT_NOP);
        add_mss(mss_pick());
      end
      repeat ($urandom_range(4)) begin
        roll = $urandom_range(99);
        if (roll < 30) pkt.push_back(OPT_NOP);
        else if (roll < 45) add_mss(mss_pick());
        else if (roll < 75) add_opt(other_kind(), $urandom_range(2, 10));
        else if (roll < 80) add_opt(OPT_MD5, 18);
        else if (roll < 85) pkt.push_back(OPT_EOL);
        else if (roll < 90) add_opt(OPT_MSS, $urandom_range(2, 8));
        else if (roll < 95) add_opt(other_kind(), $urandom_range(0, 1));
        else pkt.push_back(8'($urandom_range(255)));
      end
      close_options();
      roll = $urandom_range(99);
      if (roll < 6) begin
        repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(255)));
      end else if (roll < 10) begin
        set_doff(4'($urandom_range(15)));
      end else if (roll < 14) begin
        n = $urandom_range(1, pkt.size() - 1);
        pkt = pkt[0:n - 1];
      end
    end
    send_packet();
  endtask

  initial begin
    int b0;
    logic [15:0] lim;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pkt = {8'hff};
    send_packet();
    begin_syn(1'b1, 1'b1); add_mss(16'd1460); close_options();
    pkt = pkt[0:9];
    send_packet();
    begin_syn(1'b1, 1'b1); add_mss(16'd1460); close_options(); send_packet();
    begin_syn(1'b1, 1'b1); pkt.push_back(OPT_EOL); add_mss(16'd9000);
    close_options(); send_packet();
    begin_syn(1'b1, 1'b1); add_opt(OPT_MD5, 18); close_options(); send_packet();
    begin_syn(1'b1, 1'b1); add_opt(OPT_TSTAMP, 41); close_options(); send_packet();
    begin_syn(1'b1, 1'b1);
    repeat (3) pkt.push_back(OPT_NOP);
    pkt.push_back(OPT_TSTAMP);
    close_options(); send_packet();
    begin_syn(1'b1, 1'b1); add_mss(16'd9000); close_options();
    while (pkt.size() < 130) pkt.push_back(8'($urandom_range(255)));
    send_packet();

    for (int seg = 0; seg < 6; seg++) begin
      settle();
      case (seg)
        0: lim = 16'd0;
        1: lim = 16'hffff;
        3: lim = 16'd536;
        5: lim = 16'd1460;
        default: lim = 16'($urandom);
      endcase
      set_limit(lim);
      case (seg / 2)
        0: begin
          send_idle = 25;
          recv_idle = 83;
        end
        1: begin
          send_idle = 83;
          recv_idle = 25;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (seg == 0) begin
        hold_left = 300;
        repeat (12) begin
          pkt.delete();
          repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom_range(255)));
          send_packet();
        end
      end
      b0 = bytes_sent;
      while (bytes_sent - b0 < 30) random_packet();
    end

    settle();
    if (errors == 0 && waiting == 0) begin
      $display("[tcp_syn_mss_clamp] OK");
    end else begin
      $display("[tcp_syn_mss_clamp] ERROR");
    end
    $finish;
  end

endmodule
